[hw/rtl/box_filter_edge_clipped_mean_unit_macros.svh]
// Assertion macros used by the box filter top level.
`ifndef BOX_FILTER_EDGE_CLIPPED_MEAN_UNIT_MACROS_SVH
`define BOX_FILTER_EDGE_CLIPPED_MEAN_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define BFM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define BFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/bfm_pkg.sv]
// Types and constants of the box filter mean unit.
package bfm_pkg;

  localparam int MAX_HEIGHT   = 4096;
  localparam int HEIGHT_W     = 13;
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int WIN_REG_W    = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_ADDR_W   = 2;
  localparam int PIX_W        = 8;
  localparam int HALF_W       = 2;
  localparam int SPAN_W       = 3;
  localparam int SUM_W        = 14;
  localparam int CNT_W        = 6;
  localparam int STEP_W       = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd512;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 13'd512;
  localparam logic [WIN_REG_W-1:0]   WIN_RESET    = 3'd5;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] smoothed_pixel;
    logic             frame_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_START,
    ST_DIV,
    ST_OUT
  } bfm_state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quot;
  } div_rsp_t;

endpackage

[hw/rtl/bfm_line_mem.sv]
// Line store memory: one write port and one registered read port.
module bfm_line_mem #(
  parameter int DEPTH = 6151,
  parameter int AW    = 13
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bfm_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [bfm_pkg::PIX_W-1:0] rd_data
);

  logic [bfm_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/bfm_div.sv]
// Restoring divider giving an 8-bit quotient of the window sum by the pixel count.
module bfm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bfm_pkg::div_req_t req,
  output bfm_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [bfm_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic [bfm_pkg::SUM_W-1:0]         rem_r, rem_nxt;
  logic [bfm_pkg::SUM_W-1:0]         dvs_r, dvs_nxt;
  logic [bfm_pkg::PIX_W-1:0]         quot_r, quot_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = req.sum;
      dvs_nxt  = bfm_pkg::SUM_W'(req.cnt) << (bfm_pkg::PIX_W - 1);
      quot_nxt = '0;
    end else if (busy_r) begin
      if (rem_r >= dvs_r) begin
        rem_nxt  = rem_r - dvs_r;
        quot_nxt = {quot_r[bfm_pkg::PIX_W-2:0], 1'b1};
      end else begin
        quot_nxt = {quot_r[bfm_pkg::PIX_W-2:0], 1'b0};
      end
      dvs_nxt  = dvs_r >> 1;
      step_nxt = step_r + 1'b1;
      if (step_r == bfm_pkg::STEP_W'(bfm_pkg::PIX_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

[hw/rtl/box_filter_edge_clipped_mean_unit.sv]
// Top level of the box filter mean unit with border renormalization.
//
// Pixels enter in raster order on the in_ channel (valid/ready); req_type
// marks a flush tick that carries no pixel. Each result on the out_ channel
// is the truncated mean of the in-image part of the square window around one
// pixel, in raster order, starting after half*width+half counted items.
// Items that give no result are taken at one per cycle. An item that gives a
// result occupies the unit while its in-image window is read one pixel
// per cycle from the single read port of the line store and an 8-step
// divider then forms the mean.
// The out_ register holds a finished result while the next item is taken;
// a stalled receiver only blocks the unit once the next result is ready.
// Reset (rst_n, synchronous) clears all control state and restores the
// default geometry; the line store is not cleared, as every window read hits
// a pixel written earlier in the same frame. A cfg_ write to a defined address
// restarts the frame. frame_last marks the result for the final pixel of the image.
`include "box_filter_edge_clipped_mean_unit_macros.svh"

module box_filter_edge_clipped_mean_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bfm_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bfm_pkg::out_item_t             out_payload,
  input  logic                           cfg_we,
  input  logic [bfm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bfm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = (MAX_WINDOW - 1) * MAX_WIDTH + MAX_WINDOW;
  localparam int AW     = $clog2(DEPTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int HF_RAW = ((MAX_WINDOW - 1) | 1) / 2;
  localparam int HF_LIM = (HF_RAW > 3) ? 3 : HF_RAW;

  function automatic logic [AW-1:0] times_small(input logic [bfm_pkg::HALF_W-1:0] k,
                                                input logic [AW-1:0] v);
    logic [AW-1:0] p;
    case (k)
      2'd0: begin
        p = '0;
      end
      2'd1: begin
        p = v;
      end
      2'd2: begin
        p = v << 1;
      end
      default: begin
        p = (v << 1) + v;
      end
    endcase
    return p;
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (32'(a) == DEPTH - 1) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

  logic [bfm_pkg::WIDTH_REG_W-1:0] width_cfg_r, width_cfg_nxt;
  logic [bfm_pkg::HEIGHT_W-1:0]    height_cfg_r, height_cfg_nxt;
  logic [bfm_pkg::WIN_REG_W-1:0]   win_cfg_r, win_cfg_nxt;

  bfm_pkg::bfm_state_t             state_r, state_nxt;
  logic [AW-1:0]                   wr_addr_r, wr_addr_nxt;
  logic [CW-1:0]                   in_col_r, in_col_nxt;
  logic [bfm_pkg::HEIGHT_W-1:0]    in_row_r, in_row_nxt;
  logic [AW-1:0]                   pre_cnt_r, pre_cnt_nxt;
  logic [AW-1:0]                   ctr_addr_r, ctr_addr_nxt;
  logic [CW-1:0]                   out_col_r, out_col_nxt;
  logic [bfm_pkg::ROW_W-1:0]       out_row_r, out_row_nxt;
  logic                            rd_valid_r;
  logic                            out_valid_r, out_valid_nxt;

  logic [AW-1:0]                   row_addr_r, row_addr_nxt;
  logic [AW-1:0]                   col_addr_r, col_addr_nxt;
  logic [bfm_pkg::SPAN_W-1:0]      rows_left_r, rows_left_nxt;
  logic [bfm_pkg::SPAN_W-1:0]      col_left_r, col_left_nxt;
  logic [bfm_pkg::SPAN_W-1:0]      cols_m1_r, cols_m1_nxt;
  logic [bfm_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [bfm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  bfm_pkg::out_item_t              out_payload_r, out_payload_nxt;

  logic [W_W-1:0]                  eff_w;
  logic [bfm_pkg::HEIGHT_W-1:0]    eff_h;
  logic [bfm_pkg::WIN_REG_W-1:0]   win_odd;
  logic [bfm_pkg::HALF_W-1:0]      hf;
  logic [AW-1:0]                   w_a;
  logic [AW-1:0]                   lag;
  logic [CW-1:0]                   col_last;
  logic [bfm_pkg::ROW_W-1:0]       row_last;
  logic [bfm_pkg::ROW_W-1:0]       rows_below;
  logic [CW-1:0]                   cols_right;
  logic [bfm_pkg::HALF_W-1:0]      dr0, dn, dc0, dcn;
  logic [bfm_pkg::SPAN_W-1:0]      rows_m1, cols_m1;
  logic [AW-1:0]                   off;
  logic [AW-1:0]                   start_addr;
  logic [AW:0]                     next_row_sum;
  logic [AW-1:0]                   next_row_addr;
  logic                            in_fire;
  logic                            full;
  logic                            store;
  logic                            counted;
  logic                            last_pos;
  logic                            out_load;
  logic                            restart;
  logic                            mem_we;
  logic                            mem_re;
  logic [bfm_pkg::PIX_W-1:0]       mem_rdata;
  bfm_pkg::div_req_t               div_req;
  bfm_pkg::div_rsp_t               div_rsp;

  // Effective geometry from the raw register values.
  always_comb begin
    if (width_cfg_r == '0) begin
      eff_w = W_W'(1);
    end else if (32'(width_cfg_r) > MAX_WIDTH) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      eff_h = bfm_pkg::HEIGHT_W'(1);
    end else if (32'(height_cfg_r) > bfm_pkg::MAX_HEIGHT) begin
      eff_h = bfm_pkg::HEIGHT_W'(bfm_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_cfg_r;
    end
    win_odd = win_cfg_r | bfm_pkg::WIN_REG_W'(1);
    if (32'(win_odd) > MAX_WINDOW) begin
      hf = bfm_pkg::HALF_W'(HF_LIM);
    end else begin
      hf = win_odd[bfm_pkg::WIN_REG_W-1:1];
    end
  end

  // Window bounds around the next output position, clipped to the image.
  always_comb begin
    w_a        = AW'(eff_w);
    lag        = times_small(hf, w_a) + AW'(hf);
    col_last   = CW'(eff_w - W_W'(1));
    row_last   = bfm_pkg::ROW_W'(eff_h - bfm_pkg::HEIGHT_W'(1));
    rows_below = row_last - out_row_r;
    cols_right = col_last - out_col_r;
    dr0 = (out_row_r < bfm_pkg::ROW_W'(hf)) ? out_row_r[bfm_pkg::HALF_W-1:0] : hf;
    dn  = (rows_below < bfm_pkg::ROW_W'(hf)) ? rows_below[bfm_pkg::HALF_W-1:0] : hf;
    dc0 = (out_col_r < CW'(hf)) ? out_col_r[bfm_pkg::HALF_W-1:0] : hf;
    dcn = (cols_right < CW'(hf)) ? cols_right[bfm_pkg::HALF_W-1:0] : hf;
    rows_m1 = bfm_pkg::SPAN_W'(dr0) + bfm_pkg::SPAN_W'(dn);
    cols_m1 = bfm_pkg::SPAN_W'(dc0) + bfm_pkg::SPAN_W'(dcn);
    off = times_small(dr0, w_a) + AW'(dc0);
    if (ctr_addr_r >= off) begin
      start_addr = ctr_addr_r - off;
    end else begin
      start_addr = AW'({1'b0, ctr_addr_r} + (AW + 1)'(DEPTH) - {1'b0, off});
    end
    next_row_sum = {1'b0, row_addr_r} + {1'b0, w_a};
    if (32'(next_row_sum) >= DEPTH) begin
      next_row_addr = AW'(next_row_sum - (AW + 1)'(DEPTH));
    end else begin
      next_row_addr = AW'(next_row_sum);
    end
  end

  assign in_ready = (state_r == bfm_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (in_row_r == eff_h);
  assign store    = !full && (in_data.req_type == bfm_pkg::REQ_PIXEL);
  assign counted  = full || (in_data.req_type == bfm_pkg::REQ_PIXEL);
  assign last_pos = (out_row_r == row_last) && (out_col_r == col_last);

  always_comb begin
    state_nxt       = state_r;
    wr_addr_nxt     = wr_addr_r;
    in_col_nxt      = in_col_r;
    in_row_nxt      = in_row_r;
    pre_cnt_nxt     = pre_cnt_r;
    ctr_addr_nxt    = ctr_addr_r;
    out_col_nxt     = out_col_r;
    out_row_nxt     = out_row_r;
    row_addr_nxt    = row_addr_r;
    col_addr_nxt    = col_addr_r;
    rows_left_nxt   = rows_left_r;
    col_left_nxt    = col_left_r;
    cols_m1_nxt     = cols_m1_r;
    sum_nxt         = sum_r;
    cnt_nxt         = cnt_r;
    out_payload_nxt = out_payload_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    width_cfg_nxt   = width_cfg_r;
    height_cfg_nxt  = height_cfg_r;
    win_cfg_nxt     = win_cfg_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    out_load        = 1'b0;
    restart         = 1'b0;
    div_req.start   = 1'b0;
    div_req.sum     = sum_r;
    div_req.cnt     = cnt_r;

    if (rd_valid_r) begin
      sum_nxt = sum_r + bfm_pkg::SUM_W'(mem_rdata);
      cnt_nxt = cnt_r + 1'b1;
    end

    case (state_r)
      bfm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (store) begin
            mem_we      = 1'b1;
            wr_addr_nxt = wrap_inc(wr_addr_r);
            if (in_col_r == col_last) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + 1'b1;
            end else begin
              in_col_nxt = in_col_r + 1'b1;
            end
          end
          if (counted) begin
            if (pre_cnt_r != lag) begin
              pre_cnt_nxt = pre_cnt_r + 1'b1;
            end else begin
              row_addr_nxt  = start_addr;
              col_addr_nxt  = start_addr;
              rows_left_nxt = rows_m1;
              col_left_nxt  = cols_m1;
              cols_m1_nxt   = cols_m1;
              sum_nxt       = '0;
              cnt_nxt       = '0;
              state_nxt     = bfm_pkg::ST_READ;
            end
          end
        end
      end
      bfm_pkg::ST_READ: begin
        mem_re = 1'b1;
        if (col_left_r != '0) begin
          col_addr_nxt = wrap_inc(col_addr_r);
          col_left_nxt = col_left_r - 1'b1;
        end else if (rows_left_r != '0) begin
          row_addr_nxt  = next_row_addr;
          col_addr_nxt  = next_row_addr;
          col_left_nxt  = cols_m1_r;
          rows_left_nxt = rows_left_r - 1'b1;
        end else begin
          state_nxt = bfm_pkg::ST_DRAIN;
        end
      end
      bfm_pkg::ST_DRAIN: begin
        state_nxt = bfm_pkg::ST_START;
      end
      bfm_pkg::ST_START: begin
        div_req.start = 1'b1;
        state_nxt     = bfm_pkg::ST_DIV;
      end
      bfm_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = bfm_pkg::ST_OUT;
        end
      end
      bfm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load                       = 1'b1;
          out_valid_nxt                  = 1'b1;
          out_payload_nxt.smoothed_pixel = div_rsp.quot;
          out_payload_nxt.frame_last     = last_pos;
          state_nxt                      = bfm_pkg::ST_IDLE;
          if (last_pos) begin
            restart = 1'b1;
          end else begin
            ctr_addr_nxt = wrap_inc(ctr_addr_r);
            if (out_col_r == col_last) begin
              out_col_nxt = '0;
              out_row_nxt = out_row_r + 1'b1;
            end else begin
              out_col_nxt = out_col_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = bfm_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_addr)
        bfm_pkg::CFG_IMAGE_WIDTH: begin
          width_cfg_nxt = cfg_wdata[bfm_pkg::WIDTH_REG_W-1:0];
          restart       = 1'b1;
        end
        bfm_pkg::CFG_IMAGE_HEIGHT: begin
          height_cfg_nxt = cfg_wdata[bfm_pkg::HEIGHT_W-1:0];
          restart        = 1'b1;
        end
        bfm_pkg::CFG_WINDOW_SIZE: begin
          win_cfg_nxt = cfg_wdata[bfm_pkg::WIN_REG_W-1:0];
          restart     = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (restart) begin
      wr_addr_nxt  = '0;
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      pre_cnt_nxt  = '0;
      ctr_addr_nxt = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfm_pkg::ST_IDLE;
      wr_addr_r    <= '0;
      in_col_r     <= '0;
      in_row_r     <= '0;
      pre_cnt_r    <= '0;
      ctr_addr_r   <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      rd_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      width_cfg_r  <= bfm_pkg::WIDTH_RESET;
      height_cfg_r <= bfm_pkg::HEIGHT_RESET;
      win_cfg_r    <= bfm_pkg::WIN_RESET;
    end else begin
      state_r      <= state_nxt;
      wr_addr_r    <= wr_addr_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      pre_cnt_r    <= pre_cnt_nxt;
      ctr_addr_r   <= ctr_addr_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      rd_valid_r   <= mem_re;
      out_valid_r  <= out_valid_nxt;
      width_cfg_r  <= width_cfg_nxt;
      height_cfg_r <= height_cfg_nxt;
      win_cfg_r    <= win_cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_addr_r    <= row_addr_nxt;
    col_addr_r    <= col_addr_nxt;
    rows_left_r   <= rows_left_nxt;
    col_left_r    <= col_left_nxt;
    cols_m1_r     <= cols_m1_nxt;
    sum_r         <= sum_nxt;
    cnt_r         <= cnt_nxt;
    out_payload_r <= out_payload_nxt;
  end

  bfm_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr_r),
    .wr_data (in_data.pixel_in),
    .rd_en   (mem_re),
    .rd_addr (col_addr_r),
    .rd_data (mem_rdata)
  );

  bfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

  `BFM_ASSERT_SAME(a_quot_bounds, div_rsp.done, (16'(div_rsp.quot) * 16'(cnt_r) <= 16'(sum_r)) && (16'(sum_r) < (16'(div_rsp.quot) + 16'd1) * 16'(cnt_r)), "divider quotient does not match window sum and count")
  `BFM_ASSERT_SAME(a_cnt_nonzero, state_r == bfm_pkg::ST_START, cnt_r != '0, "division started with an empty window")
  `BFM_ASSERT_NEXT(a_load_done, out_load, out_valid_r && (state_r == bfm_pkg::ST_IDLE), "result load did not reach the output register")
  `BFM_ASSERT_NEXT(a_frame_restart, out_load && last_pos, (out_row_r == '0) && (out_col_r == '0) && (pre_cnt_r == '0) && (in_row_r == '0), "frame counters not cleared after the last result")
  `BFM_ASSERT_SAME(a_addr_range, 1'b1, (32'(wr_addr_r) < DEPTH) && (32'(ctr_addr_r) < DEPTH), "line store address beyond its depth")

endmodule
